### rtl/scmp_pkg.sv
// shared types, sizes and codes of the s-curve move planner
`default_nettype none
package scmp_pkg;

  localparam int SEGMENTS  = 15;
  localparam int DEPTH     = 2 * SEGMENTS + 1;
  localparam int IDX_W     = 5;
  localparam int STEP_W    = 16;
  localparam int TOT_W     = 24;
  localparam int PEAK_W    = 4;
  localparam int MASK_W    = 4;
  localparam int SEL_W     = 2;
  localparam int I_W       = $clog2(SEGMENTS + 1);
  localparam int SUM_W     = STEP_W + $clog2(SEGMENTS + 1);
  localparam int MEM_DEPTH = 3 * (1 << IDX_W);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int Q_DEPTH   = 2;
  localparam int QP_W      = $clog2(Q_DEPTH);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PLAN = 1'b1;

  localparam logic [SEL_W-1:0] TABLE_FULL       = 2'd0;
  localparam logic [SEL_W-1:0] TABLE_TWO_THIRDS = 2'd1;
  localparam logic [SEL_W-1:0] TABLE_ONE_THIRD  = 2'd2;
  localparam logic [SEL_W-1:0] TABLE_NONE       = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ZERO    = 2'd1;
  localparam logic [1:0] STAT_NOMOTOR = 2'd2;

  localparam logic [1:0] PROF_TRUNC = 2'd3;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_PLAN,
    KIND_REPORT
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_CHECK,
    S_WALK,
    S_TAIL,
    S_FIN
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEL_W-1:0]  tsel;
    logic [IDX_W-1:0]  idx;
    logic [STEP_W-1:0] steps;
    logic [1:0]        motor;
    logic [1:0]        status;
    logic [TOT_W-1:0]  total;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

### rtl/scmp_front.sv
// request intake: decodes motor and status, sorts loads and plans, drops bad loads
`default_nettype none
module scmp_front (
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_action,
  input  wire logic [1:0]                 in_table_select,
  input  wire logic [4:0]                 in_entry_index,
  input  wire logic [15:0]                in_entry_steps,
  input  wire logic [3:0]                 in_motor_mask,
  input  wire logic [23:0]                in_total_steps,
  input  wire logic                       q_full,
  output logic                            push,
  output scmp_pkg::cmd_t                  push_cmd
);
  import scmp_pkg::*;

  logic load_ok;
  logic [1:0] motor;
  logic [1:0] status;

  always_comb begin
    priority if (in_motor_mask[3]) begin
      motor = 2'd3;
    end else if (in_motor_mask[2]) begin
      motor = 2'd2;
    end else if (in_motor_mask[1]) begin
      motor = 2'd1;
    end else begin
      motor = 2'd0;
    end
  end

  always_comb begin
    priority if (in_motor_mask == '0) begin
      status = STAT_NOMOTOR;
    end else if (in_total_steps == '0) begin
      status = STAT_ZERO;
    end else begin
      status = STAT_OK;
    end
  end

  assign load_ok = (in_table_select != TABLE_NONE) && (in_entry_index <= IDX_W'(DEPTH - 1));

  always_comb begin
    push_cmd.tsel   = in_table_select;
    push_cmd.idx    = in_entry_index;
    push_cmd.steps  = in_entry_steps;
    push_cmd.motor  = motor;
    push_cmd.status = status;
    push_cmd.total  = in_total_steps;
    if (in_action == ACT_LOAD) begin
      push_cmd.kind = KIND_LOAD;
    end else if (status == STAT_OK) begin
      push_cmd.kind = KIND_PLAN;
    end else begin
      push_cmd.kind = KIND_REPORT;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && ((in_action == ACT_PLAN) || load_ok);

endmodule
`default_nettype wire

### rtl/scmp_queue.sv
// two-entry command queue between intake and sequencer
`default_nettype none
module scmp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire scmp_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output scmp_pkg::q_head_t   head
);
  import scmp_pkg::*;

  cmd_t            q_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QP_W:0]   cnt_r;
  logic [QP_W:0]   cnt_nxt;
  logic            do_pop;

  assign full     = (cnt_r == (QP_W+1)'(Q_DEPTH));
  assign do_pop   = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (QP_W+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (QP_W+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/scmp_back.sv
// step tables and plan sequencer with result register
`default_nettype none
module scmp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scmp_pkg::q_head_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_motor_number,
  output logic [1:0]             out_status,
  output logic [1:0]             out_profile,
  output logic [23:0]            out_accel_steps,
  output logic [23:0]            out_decel_steps,
  output logic [23:0]            out_cruise_steps,
  output logic [3:0]             out_peak_index,
  output logic [23:0]            out_peak_segment_steps
);
  import scmp_pkg::*;

  logic [STEP_W-1:0] mem [MEM_DEPTH];

  state_t            state_r;
  state_t            state_nxt;
  cmd_t              cmd_r;
  logic [SEL_W-1:0]  p_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  a_r;
  logic [SUM_W-1:0]  d_r;
  logic [TOT_W-1:0]  count_r;
  logic [I_W-1:0]    i_r;
  logic              tr_r;
  logic [STEP_W-1:0] rd_data_r;
  logic              rd_acc_r;
  logic              rd_hi_r;
  logic              out_valid_r;

  logic              wr_en;
  logic              rd_en;
  logic              rd_acc;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_load;
  logic [TOT_W-1:0]  half;
  logic [TOT_W-1:0]  sum_ad;
  logic              fit;
  logic [TOT_W:0]    walk_sum;
  logic              walk_go;
  logic [TOT_W-1:0]  peak_steps;

  assign half     = cmd_r.total >> 1;
  assign sum_ad   = TOT_W'(a_r) + TOT_W'(d_r);
  assign fit      = cmd_r.total > sum_ad;
  assign walk_sum = {1'b0, count_r} + (TOT_W+1)'(rd_data_r);
  assign walk_go  = (i_r != I_W'(SEGMENTS)) && (walk_sum < {1'b0, half});
  assign peak_steps = half - count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid && head.cmd.kind == KIND_PLAN) begin
          state_nxt = S_SUM;
        end else if (head.valid && head.cmd.kind == KIND_REPORT) begin
          state_nxt = S_FIN;
        end
      end
      S_SUM: begin
        if (cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = tr_r ? S_FIN : S_CHECK;
      end
      S_CHECK: begin
        priority if (fit) begin
          state_nxt = S_FIN;
        end else if (p_r != TABLE_ONE_THIRD) begin
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!walk_go) begin
          state_nxt = (i_r == '0) ? S_FIN : S_TAIL;
        end
      end
      S_TAIL: begin
        if (cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_acc   = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        pop   = head.valid;
        wr_en = head.valid && (head.cmd.kind == KIND_LOAD);
      end
      S_SUM: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'({p_r, cnt_r});
        rd_acc  = (cnt_r != IDX_W'(SEGMENTS));
      end
      S_CHECK: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'({TABLE_ONE_THIRD, IDX_W'(0)});
      end
      S_WALK: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'({TABLE_ONE_THIRD, IDX_W'(i_r) + IDX_W'(1)});
      end
      S_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'({TABLE_ONE_THIRD, cnt_r});
        rd_acc  = 1'b1;
      end
      S_DRAIN: begin
        rd_en = 1'b0;
      end
      S_FIN: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'({head.cmd.tsel, head.cmd.idx})] <= head.cmd.steps;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_acc_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_acc_r <= rd_acc;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_hi_r <= (cnt_r > IDX_W'(SEGMENTS));
    if (rd_acc_r) begin
      if (rd_hi_r) begin
        d_r <= d_r + SUM_W'(rd_data_r);
      end else begin
        a_r <= a_r + SUM_W'(rd_data_r);
      end
    end
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          cmd_r <= head.cmd;
          p_r   <= TABLE_FULL;
          cnt_r <= '0;
          a_r   <= '0;
          d_r   <= '0;
          tr_r  <= 1'b0;
        end
      end
      S_SUM, S_TAIL: begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      S_CHECK: begin
        if (!fit) begin
          if (p_r != TABLE_ONE_THIRD) begin
            p_r   <= p_r + SEL_W'(1);
            cnt_r <= '0;
            a_r   <= '0;
            d_r   <= '0;
          end else begin
            i_r     <= '0;
            count_r <= '0;
            tr_r    <= 1'b1;
          end
        end
      end
      S_WALK: begin
        if (walk_go) begin
          count_r <= walk_sum[TOT_W-1:0];
          i_r     <= i_r + I_W'(1);
        end else begin
          cnt_r <= IDX_W'(DEPTH) - IDX_W'(i_r);
          d_r   <= '0;
        end
      end
      S_DRAIN, S_FIN: begin
        cnt_r <= cnt_r;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_motor_number <= cmd_r.motor;
      out_status       <= cmd_r.status;
      if (cmd_r.kind == KIND_REPORT) begin
        out_profile            <= '0;
        out_accel_steps        <= '0;
        out_decel_steps        <= '0;
        out_cruise_steps       <= '0;
        out_peak_index         <= '0;
        out_peak_segment_steps <= '0;
      end else if (tr_r) begin
        out_profile            <= PROF_TRUNC;
        out_accel_steps        <= half;
        out_decel_steps        <= peak_steps + TOT_W'(d_r);
        out_cruise_steps       <= '0;
        out_peak_index         <= PEAK_W'(i_r);
        out_peak_segment_steps <= peak_steps;
      end else begin
        out_profile            <= p_r;
        out_accel_steps        <= TOT_W'(a_r);
        out_decel_steps        <= TOT_W'(d_r);
        out_cruise_steps       <= cmd_r.total - sum_ad;
        out_peak_index         <= '0;
        out_peak_segment_steps <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/s_curve_move_planner_core.sv
// top level of the s-curve move planner: intake, command queue, sequencer
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  action, table_select, entry_index,
//                                           entry_steps, motor_mask, total_steps
//  out_     output     out_valid/out_stall  motor_number, status, profile, accel,
//                                           decel, cruise, peak_index, peak_segment
//
//  a load request leaves the queue once the sequencer is idle and writes the table
//  in the same cycle; a plan reads each curve table in a pass of the one table memory
//  port, up to three passes, then the truncated walk and the decel tail sum, and then
//  loads the result register; a zero-length or no-motor plan goes from S_IDLE straight
//  to S_FIN and the result register without reading the tables
//  reset (synchronous, rst_n low) empties the queue and the result register; the
//  tables hold no reset value; intake stalls only when the two-entry queue is full
`default_nettype none
module s_curve_move_planner_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [1:0]  in_table_select,
  input  wire logic [4:0]  in_entry_index,
  input  wire logic [15:0] in_entry_steps,
  input  wire logic [3:0]  in_motor_mask,
  input  wire logic [23:0] in_total_steps,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_motor_number,
  output logic [1:0]       out_status,
  output logic [1:0]       out_profile,
  output logic [23:0]      out_accel_steps,
  output logic [23:0]      out_decel_steps,
  output logic [23:0]      out_cruise_steps,
  output logic [3:0]       out_peak_index,
  output logic [23:0]      out_peak_segment_steps
);
  import scmp_pkg::*;

  logic    q_full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  q_head_t head;

  scmp_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_entry_steps  (in_entry_steps),
    .in_motor_mask   (in_motor_mask),
    .in_total_steps  (in_total_steps),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  scmp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  scmp_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (head),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_motor_number       (out_motor_number),
    .out_status             (out_status),
    .out_profile            (out_profile),
    .out_accel_steps        (out_accel_steps),
    .out_decel_steps        (out_decel_steps),
    .out_cruise_steps       (out_cruise_steps),
    .out_peak_index         (out_peak_index),
    .out_peak_segment_steps (out_peak_segment_steps)
  );

  a_report_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_accel_steps == '0 && out_decel_steps == '0 && out_cruise_steps == '0
       && out_peak_index == '0 && out_profile == '0))
    else $error("non-planned result carries step counts");

  a_trunc_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_profile == PROF_TRUNC) |->
      (out_cruise_steps == '0 && out_decel_steps >= out_peak_segment_steps
       && out_accel_steps >= out_peak_segment_steps))
    else $error("truncated result fields inconsistent");

  a_full_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_profile != PROF_TRUNC) |->
      (out_peak_index == '0 && out_peak_segment_steps == '0))
    else $error("peak fields set on a non-truncated result");

endmodule
`default_nettype wire
